FILE: src/tdpc_pkg.sv
// Package for the trial-division prime counter.
// Holds field widths and derived constants; no dependencies.
package tdpc_pkg;

    // Width of the number under test
    localparam int VALUE_WIDTH = 14;
    // Width of the saturating prime count
    localparam int COUNT_WIDTH = 16;
    // Bit index into the dividend, one division step per bit
    localparam int BIT_W       = $clog2(VALUE_WIDTH);
    // Top bit position of the dividend
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(VALUE_WIDTH - 1);
    // Count saturation limit
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

endpackage

FILE: src/tdpc_if.sv
// Valid/ready channel interfaces for the prime counter.
// Depends on tdpc_pkg for the field widths.

// Input channel: number to test and batch-end flag
interface tdpc_in_if
    import tdpc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

// Output channel: verdict, running count and batch-end echo
interface tdpc_out_if
    import tdpc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   is_prime;
    logic [COUNT_WIDTH-1:0] prime_count;
    logic                   batch_end;

    modport source (output valid, is_prime, prime_count, batch_end, input ready);
    modport sink   (input valid, is_prime, prime_count, batch_end, output ready);
endinterface

FILE: src/trial_division_prime_counter.sv
// Trial-division prime counter, top level.
// Depends on tdpc_pkg and the channel interfaces in tdpc_if.sv.
//
//  channel | dir | payload                              | handshake
//  i_in    | in  | value[13:0], last                    | valid/ready
//  o_out   | out | is_prime, prime_count[15:0], batch_end | valid/ready
//
// One item at a time. Each candidate divisor d (2, 3, ...) while d*d <= value
// takes one bound check, VALUE_WIDTH restoring remainder steps in the shared
// subtract/compare unit and one remainder test. Values below 4 fail the first
// bound check and go to the finish state. The search stops on the first divisor.
// Synchronous active-low reset clears the sequencer, the count and o_out.valid.
// The result sits in an output register; a new item is taken while it waits,
// and the next result waits in the finish state until that register frees.
module trial_division_prime_counter
    import tdpc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdpc_in_if.sink      i_in,
    tdpc_out_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EVAL,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_last;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH:0]   r_sq;
    logic [VALUE_WIDTH:0]   r_rem;
    logic [BIT_W-1:0]       r_bit;
    logic                   r_prime;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   r_o_valid;
    logic                   r_o_prime;
    logic [COUNT_WIDTH-1:0] r_o_count;
    logic                   r_o_end;

    logic [VALUE_WIDTH:0]   n_shift;
    logic [VALUE_WIDTH:0]   n_rem;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_o_valid;
    logic                   out_free;

    // Shared remainder unit: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_shift = {r_rem[VALUE_WIDTH-1:0], r_val[r_bit]};
        if (n_shift >= {1'b0, r_div}) begin
            n_rem = n_shift - {1'b0, r_div};
        end else begin
            n_rem = n_shift;
        end
    end

    // Saturating count including the item being finished
    always_comb begin
        if (r_prime && (r_count != COUNT_MAX)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    // Output register valid: freed when taken, loaded when a result completes
    always_comb begin
        n_o_valid = r_o_valid && !o_out.ready;
        if ((r_state == S_DONE) && out_free) begin
            n_o_valid = 1'b1;
        end
    end

    assign out_free    = !r_o_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid       = r_o_valid;
    assign o_out.is_prime    = r_o_prime;
    assign o_out.prime_count = r_o_count;
    assign o_out.batch_end   = r_o_end;

    // Sequencer, search registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_val   <= i_in.value;
                        r_last  <= i_in.last;
                        r_div   <= VALUE_WIDTH'(2);
                        r_sq    <= (VALUE_WIDTH + 1)'(4);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Past the square root: no divisor exists
                    if (r_sq > {1'b0, r_val}) begin
                        r_prime <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= '0;
                        r_bit   <= BIT_TOP;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_rem == '0) begin
                        r_prime <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        r_div   <= r_div + 1'b1;
                        r_sq    <= r_sq + {r_div, 1'b1};
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_prime <= r_prime;
                        r_o_count <= n_count;
                        r_o_end   <= r_last;
                        r_count   <= r_last ? '0 : n_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_prime_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_prime |-> o_out.prime_count != '0)
        else $error("prime reported with zero count");

    a_square_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
            r_sq == (VALUE_WIDTH + 1)'({1'b0, r_div} * {1'b0, r_div}))
        else $error("divisor square out of step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> r_rem < {1'b0, r_div})
        else $error("remainder not below divisor");

    a_div_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_div >= VALUE_WIDTH'(2))
        else $error("divisor below two");

endmodule
